// ===== design/segment_pair_cutoff_test_core_assert.svh =====
// Assertion macros for the segment pair cutoff test port checker
`ifndef SEGMENT_PAIR_CUTOFF_TEST_CORE_ASSERT_SVH
`define SEGMENT_PAIR_CUTOFF_TEST_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SPCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spct assertion failed");

// Implication after a fixed number of cycles, disabled during reset
`define SPCT_ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("spct assertion failed");

`endif

// ===== design/spct_pkg.sv =====
// Types, widths and arithmetic helpers for the segment pair cutoff test
package spct_pkg;

    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int P1_W         = 2 * DIFF_W;
    localparam int CR_W         = P1_W + 1;
    localparam int P2_W         = 2 * CR_W;
    localparam int D_W          = 70;
    localparam int DOT_W        = P2_W + 2;
    localparam int HALF_W       = 35;
    localparam int SP_W         = DIFF_W + HALF_W + 1;
    localparam int CUTOFF_W     = 32;
    localparam int THR_W        = 63;
    localparam int CFG_W        = 63;
    localparam int CP_W         = CUTOFF_W + HALF_W;
    localparam int W_W          = 89;
    localparam int WABS_W       = W_W - 1;
    localparam int L1_W         = CUTOFF_W + D_W;
    localparam int L1_PART      = 34;
    localparam int LP_W         = L1_PART + HALF_W;
    localparam int L2_W         = CUTOFF_W + 2 * D_W;
    localparam int CH_W         = 30;
    localparam int SQ_W         = 2 * CH_W;
    localparam int SQ_SUM_W     = 176;
    localparam int MAG_W        = SQ_SUM_W + 2;
    localparam int CROSS_STAGES = 5;
    localparam int MAG_STAGES   = 4;
    localparam int LATENCY      = 13;

    typedef enum logic {
        CFG_CUTOFF_SQ = 1'b0,
        CFG_PAR_THR   = 1'b1
    } t_cfg_idx;

    typedef logic signed [DIFF_W-1:0] t_diff;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_pt;

    typedef struct packed {
        t_pt pis;
        t_pt pie;
        t_pt pjs;
        t_pt pje;
    } t_seg;

    typedef struct packed {
        t_diff x;
        t_diff y;
        t_diff z;
    } t_dvec;

    typedef struct packed {
        t_dvec a;
        t_dvec b;
        t_dvec c;
    } t_abc;

    typedef struct packed {
        logic signed [P1_W-1:0] p0;
        logic signed [P1_W-1:0] p1;
        logic signed [P1_W-1:0] p2;
        logic signed [P1_W-1:0] p3;
        logic signed [P1_W-1:0] p4;
        logic signed [P1_W-1:0] p5;
    } t_pp;

    typedef struct packed {
        logic signed [CR_W-1:0] x;
        logic signed [CR_W-1:0] y;
        logic signed [CR_W-1:0] z;
    } t_cvec;

    typedef struct packed {
        logic signed [P2_W-1:0] x;
        logic signed [P2_W-1:0] y;
        logic signed [P2_W-1:0] z;
    } t_dp;

    typedef struct packed {
        logic signed [SP_W-1:0] xl;
        logic signed [SP_W-1:0] xh;
        logic signed [SP_W-1:0] yl;
        logic signed [SP_W-1:0] yh;
        logic signed [SP_W-1:0] zl;
        logic signed [SP_W-1:0] zh;
    } t_sp;

    typedef struct packed {
        logic signed [W_W-1:0] x;
        logic signed [W_W-1:0] y;
        logic signed [W_W-1:0] z;
    } t_wvec;

    typedef struct packed {
        logic [SQ_W-1:0] s00;
        logic [SQ_W-1:0] s11;
        logic [SQ_W-1:0] s22;
        logic [SQ_W-1:0] s01;
        logic [SQ_W-1:0] s02;
        logic [SQ_W-1:0] s12;
    } t_sqp;

    typedef struct packed {
        logic                    valid;
        t_abc                    abc;
        logic [D_W-1:0]          d;
        logic signed [DOT_W-1:0] sn;
        logic signed [DOT_W-1:0] tn;
    } t_cross_out;

    typedef struct packed {
        logic            valid;
        logic            par;
        logic            rng;
        t_wvec           w;
        logic [L1_W-1:0] l1;
        logic [D_W-1:0]  d;
    } t_scale_out;

    typedef struct packed {
        logic done;
        logic hit;
        logic par;
    } t_result;

    function automatic t_diff sub_c(logic signed [COORD_W-1:0] p,
                                    logic signed [COORD_W-1:0] q);
        return DIFF_W'(p) - DIFF_W'(q);
    endfunction

    function automatic logic signed [P1_W-1:0] mul_d(t_diff p, t_diff q);
        logic signed [P1_W-1:0] r;
        r = p * q;
        return r;
    endfunction

    // six partial products of u x v
    function automatic t_pp cross_pp(t_dvec u, t_dvec v);
        t_pp r;
        r.p0 = mul_d(u.y, v.z);
        r.p1 = mul_d(u.z, v.y);
        r.p2 = mul_d(u.z, v.x);
        r.p3 = mul_d(u.x, v.z);
        r.p4 = mul_d(u.x, v.y);
        r.p5 = mul_d(u.y, v.x);
        return r;
    endfunction

    function automatic t_cvec cross_fin(t_pp p);
        t_cvec r;
        r.x = CR_W'(p.p0) - CR_W'(p.p1);
        r.y = CR_W'(p.p2) - CR_W'(p.p3);
        r.z = CR_W'(p.p4) - CR_W'(p.p5);
        return r;
    endfunction

    function automatic t_dp dot_pp(t_cvec u, t_cvec v);
        t_dp r;
        r.x = u.x * v.x;
        r.y = u.y * v.y;
        r.z = u.z * v.z;
        return r;
    endfunction

    function automatic logic signed [DOT_W-1:0] dot_sum(t_dp p);
        return DOT_W'(p.x) + DOT_W'(p.y) + DOT_W'(p.z);
    endfunction

    function automatic logic signed [SP_W-1:0] mul_sh(t_diff p, logic [HALF_W-1:0] h);
        logic signed [HALF_W:0] hs;
        logic signed [SP_W-1:0] r;
        hs = {1'b0, h};
        r  = p * hs;
        return r;
    endfunction

    // vector times a nonnegative 70-bit scalar, as low and high half products
    function automatic t_sp scale_pp(t_dvec v, logic [2*HALF_W-1:0] m);
        t_sp r;
        r.xl = mul_sh(v.x, m[HALF_W-1:0]);
        r.xh = mul_sh(v.x, m[2*HALF_W-1:HALF_W]);
        r.yl = mul_sh(v.y, m[HALF_W-1:0]);
        r.yh = mul_sh(v.y, m[2*HALF_W-1:HALF_W]);
        r.zl = mul_sh(v.z, m[HALF_W-1:0]);
        r.zh = mul_sh(v.z, m[2*HALF_W-1:HALF_W]);
        return r;
    endfunction

    function automatic t_wvec scale_fin(t_sp p);
        t_wvec r;
        r.x = (W_W'(p.xh) <<< HALF_W) + W_W'(p.xl);
        r.y = (W_W'(p.yh) <<< HALF_W) + W_W'(p.yl);
        r.z = (W_W'(p.zh) <<< HALF_W) + W_W'(p.zl);
        return r;
    endfunction

    function automatic logic [WABS_W-1:0] abs_w(logic signed [W_W-1:0] w);
        logic signed [W_W-1:0] neg;
        neg = -w;
        return w[W_W-1] ? neg[WABS_W-1:0] : w[WABS_W-1:0];
    endfunction

    // square of an 88-bit magnitude as six 30x30 products
    function automatic t_sqp sq_pp(logic [WABS_W-1:0] m);
        logic [3*CH_W-1:0] u;
        t_sqp r;
        u     = (3*CH_W)'(m);
        r.s00 = SQ_W'(u[CH_W-1:0])        * SQ_W'(u[CH_W-1:0]);
        r.s11 = SQ_W'(u[2*CH_W-1:CH_W])   * SQ_W'(u[2*CH_W-1:CH_W]);
        r.s22 = SQ_W'(u[3*CH_W-1:2*CH_W]) * SQ_W'(u[3*CH_W-1:2*CH_W]);
        r.s01 = SQ_W'(u[CH_W-1:0])        * SQ_W'(u[2*CH_W-1:CH_W]);
        r.s02 = SQ_W'(u[CH_W-1:0])        * SQ_W'(u[3*CH_W-1:2*CH_W]);
        r.s12 = SQ_W'(u[2*CH_W-1:CH_W])   * SQ_W'(u[3*CH_W-1:2*CH_W]);
        return r;
    endfunction

    function automatic logic [SQ_SUM_W-1:0] sq_fin(t_sqp p);
        return SQ_SUM_W'(p.s00)
             + (SQ_SUM_W'(p.s01) << (CH_W + 1))
             + ((SQ_SUM_W'(p.s11) + (SQ_SUM_W'(p.s02) << 1)) << (2 * CH_W))
             + (SQ_SUM_W'(p.s12) << (3 * CH_W + 1))
             + (SQ_SUM_W'(p.s22) << (4 * CH_W));
    endfunction

endpackage

// ===== design/spct_cross.sv =====
// Front pipeline: edge vectors, cross products and the D, sn, tn dot products
module spct_cross import spct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_seg       i_seg,
    output t_cross_out o_cross
);

    logic [CROSS_STAGES-1:0] r_v;
    t_abc                    r_abc [CROSS_STAGES];
    t_abc                    n_abc;
    t_pp                     r_pn, r_pcb, r_pca;
    t_cvec                   r_n, r_cb, r_ca;
    t_dp                     r_qd, r_qs, r_qt;
    logic signed [DOT_W-1:0] r_dsum, r_sn, r_tn;

    always_comb begin
        n_abc.a.x = sub_c(i_seg.pie.x, i_seg.pis.x);
        n_abc.a.y = sub_c(i_seg.pie.y, i_seg.pis.y);
        n_abc.a.z = sub_c(i_seg.pie.z, i_seg.pis.z);
        n_abc.b.x = sub_c(i_seg.pje.x, i_seg.pjs.x);
        n_abc.b.y = sub_c(i_seg.pje.y, i_seg.pjs.y);
        n_abc.b.z = sub_c(i_seg.pje.z, i_seg.pjs.z);
        n_abc.c.x = sub_c(i_seg.pjs.x, i_seg.pis.x);
        n_abc.c.y = sub_c(i_seg.pjs.y, i_seg.pis.y);
        n_abc.c.z = sub_c(i_seg.pjs.z, i_seg.pis.z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[CROSS_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_abc[0] <= n_abc;
        for (int i = 1; i < CROSS_STAGES; i++) begin
            r_abc[i] <= r_abc[i-1];
        end
        r_pn   <= cross_pp(r_abc[0].a, r_abc[0].b);
        r_pcb  <= cross_pp(r_abc[0].c, r_abc[0].b);
        r_pca  <= cross_pp(r_abc[0].c, r_abc[0].a);
        r_n    <= cross_fin(r_pn);
        r_cb   <= cross_fin(r_pcb);
        r_ca   <= cross_fin(r_pca);
        r_qd   <= dot_pp(r_n, r_n);
        r_qs   <= dot_pp(r_cb, r_n);
        r_qt   <= dot_pp(r_ca, r_n);
        r_dsum <= dot_sum(r_qd);
        r_sn   <= dot_sum(r_qs);
        r_tn   <= dot_sum(r_qt);
    end

    always_comb begin
        o_cross.valid = r_v[CROSS_STAGES-1];
        o_cross.abc   = r_abc[CROSS_STAGES-1];
        o_cross.d     = r_dsum[D_W-1:0];
        o_cross.sn    = r_sn;
        o_cross.tn    = r_tn;
    end

endmodule

// ===== design/spct_scale.sv =====
// Middle pipeline: parallel and range tests, w = a*sn - b*tn - D*c, cutoff*D
module spct_scale import spct_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cross_out          i_cross,
    input  logic [CUTOFF_W-1:0] i_cutoff,
    input  logic [THR_W-1:0]    i_thr,
    output t_scale_out          o_scale
);

    logic [2:0]         r_v, r_par, r_rng;
    logic               n_par, n_rng;
    t_sp                r_pa6, r_pb6, r_pc6;
    logic [CP_W-1:0]    r_cl6, r_ch6;
    logic [D_W-1:0]     r_d6, r_d7, r_d8;
    t_wvec              r_wa7, r_wb7, r_wc7, r_w8;
    logic [L1_W-1:0]    r_l1_7, r_l1_8;

    // hit needs 0 <= sn <= D and 0 <= tn <= D
    always_comb begin
        n_par = (i_cross.d <= D_W'(i_thr));
        n_rng = !i_cross.sn[DOT_W-1] && (i_cross.sn[DOT_W-2:0] <= (DOT_W-1)'(i_cross.d))
             && !i_cross.tn[DOT_W-1] && (i_cross.tn[DOT_W-2:0] <= (DOT_W-1)'(i_cross.d));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_cross.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_par <= {r_par[1:0], n_par};
        r_rng <= {r_rng[1:0], n_rng};
        r_pa6 <= scale_pp(i_cross.abc.a, i_cross.sn[2*HALF_W-1:0]);
        r_pb6 <= scale_pp(i_cross.abc.b, i_cross.tn[2*HALF_W-1:0]);
        r_pc6 <= scale_pp(i_cross.abc.c, i_cross.d);
        r_cl6 <= CP_W'(i_cutoff) * CP_W'(i_cross.d[HALF_W-1:0]);
        r_ch6 <= CP_W'(i_cutoff) * CP_W'(i_cross.d[2*HALF_W-1:HALF_W]);
        r_d6  <= i_cross.d;
        r_wa7 <= scale_fin(r_pa6);
        r_wb7 <= scale_fin(r_pb6);
        r_wc7 <= scale_fin(r_pc6);
        r_l1_7 <= (L1_W'(r_ch6) << HALF_W) + L1_W'(r_cl6);
        r_d7  <= r_d6;
        r_w8.x <= r_wa7.x - r_wb7.x - r_wc7.x;
        r_w8.y <= r_wa7.y - r_wb7.y - r_wc7.y;
        r_w8.z <= r_wa7.z - r_wb7.z - r_wc7.z;
        r_l1_8 <= r_l1_7;
        r_d8  <= r_d7;
    end

    always_comb begin
        o_scale.valid = r_v[2];
        o_scale.par   = r_par[2];
        o_scale.rng   = r_rng[2];
        o_scale.w     = r_w8;
        o_scale.l1    = r_l1_8;
        o_scale.d     = r_d8;
    end

endmodule

// ===== design/spct_mag.sv =====
// Back pipeline: |w|^2 against cutoff_sq * D^2 and the result register
module spct_mag import spct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_scale_out i_scale,
    output t_result    o_result
);

    logic [MAG_STAGES-1:0] r_v, r_par, r_rng;
    logic [WABS_W-1:0]     r_wa9 [3];
    logic [LP_W-1:0]       r_lp9 [6];
    logic [L2_W-1:0]       r_q10 [3];
    t_sqp                  r_s10 [3];
    logic [L2_W-1:0]       r_l2_11, r_l2_12;
    logic [SQ_SUM_W-1:0]   r_sq11 [3];
    logic [MAG_W-1:0]      r_mag12;
    t_result               r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_res     <= '0;
        end else begin
            r_v        <= {r_v[MAG_STAGES-2:0], i_scale.valid};
            r_res.done <= r_v[MAG_STAGES-1];
            r_res.par  <= r_v[MAG_STAGES-1] && r_par[MAG_STAGES-1];
            r_res.hit  <= r_v[MAG_STAGES-1] && !r_par[MAG_STAGES-1]
                       && r_rng[MAG_STAGES-1] && (r_mag12 <= MAG_W'(r_l2_12));
        end
    end

    always_ff @(posedge i_clk) begin
        r_par <= {r_par[MAG_STAGES-2:0], i_scale.par};
        r_rng <= {r_rng[MAG_STAGES-2:0], i_scale.rng};
        r_wa9[0] <= abs_w(i_scale.w.x);
        r_wa9[1] <= abs_w(i_scale.w.y);
        r_wa9[2] <= abs_w(i_scale.w.z);
        // cutoff*D split in 34-bit pieces, D in 35-bit halves
        r_lp9[0] <= LP_W'(i_scale.l1[L1_PART-1:0]) * LP_W'(i_scale.d[HALF_W-1:0]);
        r_lp9[1] <= LP_W'(i_scale.l1[L1_PART-1:0]) * LP_W'(i_scale.d[2*HALF_W-1:HALF_W]);
        r_lp9[2] <= LP_W'(i_scale.l1[2*L1_PART-1:L1_PART]) * LP_W'(i_scale.d[HALF_W-1:0]);
        r_lp9[3] <= LP_W'(i_scale.l1[2*L1_PART-1:L1_PART])
                  * LP_W'(i_scale.d[2*HALF_W-1:HALF_W]);
        r_lp9[4] <= LP_W'(i_scale.l1[L1_W-1:2*L1_PART]) * LP_W'(i_scale.d[HALF_W-1:0]);
        r_lp9[5] <= LP_W'(i_scale.l1[L1_W-1:2*L1_PART])
                  * LP_W'(i_scale.d[2*HALF_W-1:HALF_W]);
        r_q10[0] <= L2_W'(r_lp9[0]) + (L2_W'(r_lp9[1]) << HALF_W);
        r_q10[1] <= (L2_W'(r_lp9[2]) << L1_PART) + (L2_W'(r_lp9[3]) << (L1_PART + HALF_W));
        r_q10[2] <= (L2_W'(r_lp9[4]) << (2 * L1_PART))
                  + (L2_W'(r_lp9[5]) << (2 * L1_PART + HALF_W));
        for (int k = 0; k < 3; k++) begin
            r_s10[k]  <= sq_pp(r_wa9[k]);
            r_sq11[k] <= sq_fin(r_s10[k]);
        end
        r_l2_11 <= r_q10[0] + r_q10[1] + r_q10[2];
        r_mag12 <= MAG_W'(r_sq11[0]) + MAG_W'(r_sq11[1]) + MAG_W'(r_sq11[2]);
        r_l2_12 <= r_l2_11;
    end

    assign o_result = r_res;

endmodule

// ===== design/segment_pair_cutoff_test_core.sv =====
// o_done pulses once an accepted start has passed the cross, scale and mag pipelines and the result register.
// Throughput: one transaction per cycle; busy is always low, every stage is a register.
// The delay from start to o_done is set by the 13-stage multiply/add pipeline (limited-width products).
// Reset (i_rst_n low, synchronous) clears all valid bits and both config registers.
// Results cannot be held off by the receiver; each strobe lasts one cycle.
module segment_pair_cutoff_test_core import spct_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic signed [COORD_W-1:0]  i_i_start_x,
    input  logic signed [COORD_W-1:0]  i_i_start_y,
    input  logic signed [COORD_W-1:0]  i_i_start_z,
    input  logic signed [COORD_W-1:0]  i_i_end_x,
    input  logic signed [COORD_W-1:0]  i_i_end_y,
    input  logic signed [COORD_W-1:0]  i_i_end_z,
    input  logic signed [COORD_W-1:0]  i_j_start_x,
    input  logic signed [COORD_W-1:0]  i_j_start_y,
    input  logic signed [COORD_W-1:0]  i_j_start_z,
    input  logic signed [COORD_W-1:0]  i_j_end_x,
    input  logic signed [COORD_W-1:0]  i_j_end_y,
    input  logic signed [COORD_W-1:0]  i_j_end_z,
    output logic                       o_done,
    output logic                       o_within_cutoff,
    output logic                       o_parallel
);

    logic [CUTOFF_W-1:0] r_cutoff_sq;
    logic [THR_W-1:0]    r_par_thr;
    t_seg                seg;
    t_cross_out          cross_res;
    t_scale_out          scale;
    t_result             res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_sq <= '0;
            r_par_thr   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CUTOFF_SQ: r_cutoff_sq <= i_cfg_wdata[CUTOFF_W-1:0];
                CFG_PAR_THR:   r_par_thr   <= i_cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        seg.pis = '{x: i_i_start_x, y: i_i_start_y, z: i_i_start_z};
        seg.pie = '{x: i_i_end_x,   y: i_i_end_y,   z: i_i_end_z};
        seg.pjs = '{x: i_j_start_x, y: i_j_start_y, z: i_j_start_z};
        seg.pje = '{x: i_j_end_x,   y: i_j_end_y,   z: i_j_end_z};
    end

    assign busy = 1'b0;

    spct_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_seg   (seg),
        .o_cross (cross_res)
    );

    spct_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cross  (cross_res),
        .i_cutoff (r_cutoff_sq),
        .i_thr    (r_par_thr),
        .o_scale  (scale)
    );

    spct_mag u_mag (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scale  (scale),
        .o_result (res)
    );

    assign o_done          = res.done;
    assign o_within_cutoff = res.hit;
    assign o_parallel      = res.par;

endmodule

// ===== design/spct_checker.sv =====
// Port-level checker for the segment pair cutoff test core, with its bind
`include "segment_pair_cutoff_test_core_assert.svh"

module spct_checker import spct_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_within_cutoff,
    input logic o_parallel
);

    `SPCT_ASSERT_DLY(a_done_follows, i_clk, i_rst_n, start && !busy, LATENCY, o_done)
    `SPCT_ASSERT_IMP(a_done_has_src, i_clk, i_rst_n, o_done, $past(start && !busy, LATENCY))
    `SPCT_ASSERT_IMP(a_hit_not_par, i_clk, i_rst_n, o_within_cutoff, o_done && !o_parallel)
    `SPCT_ASSERT_IMP(a_par_quiet, i_clk, i_rst_n, !o_done, !o_parallel)

endmodule

bind segment_pair_cutoff_test_core spct_checker u_spct_checker (.*);

// ===== bench/spct_checker.sv =====
// Checker for the segment pair cutoff test core: predicts each result and compares
module spct_scoreboard import spct_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_seg             i_seg,
    input  logic             i_done,
    input  logic             i_within,
    input  logic             i_parallel,
    output int               o_mismatches,
    output int               o_pending
);

    typedef logic signed [255:0] t_wide;
    typedef t_wide t_wv [3];

    typedef struct packed {
        logic hit;
        logic par;
    } t_verdict;

    t_verdict          verdict_q[$];
    logic [31:0]       cutoff_sq;
    logic [THR_W-1:0]  par_thr;
    int                errors;

    assign o_mismatches = errors;
    assign o_pending    = verdict_q.size();

    function automatic t_wide widen(logic signed [COORD_W-1:0] v);
        t_wide r;
        r = v;
        return r;
    endfunction

    function automatic t_wv cross3(t_wv u, t_wv v);
        t_wv r;
        r[0] = u[1] * v[2] - u[2] * v[1];
        r[1] = u[2] * v[0] - u[0] * v[2];
        r[2] = u[0] * v[1] - u[1] * v[0];
        return r;
    endfunction

    function automatic t_wide dot3(t_wv u, t_wv v);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function automatic t_wv span(t_pt hi, t_pt lo);
        t_wv r;
        r[0] = widen(hi.x) - widen(lo.x);
        r[1] = widen(hi.y) - widen(lo.y);
        r[2] = widen(hi.z) - widen(lo.z);
        return r;
    endfunction

    // exact closest-approach test, scaled by D so nothing is divided
    function automatic t_verdict closest_approach(t_seg s, logic [31:0] cut,
                                                  logic [THR_W-1:0] thr);
        t_wv      a, b, c, n, w;
        t_wide    d, sn, tn, mag, lim, thr_w, cut_w;
        t_verdict r;
        a = span(s.pie, s.pis);
        b = span(s.pje, s.pjs);
        c = span(s.pjs, s.pis);
        n = cross3(a, b);
        d = dot3(n, n);
        thr_w = {193'b0, thr};
        cut_w = {224'b0, cut};
        r.par = (d <= thr_w);
        r.hit = 1'b0;
        if (!r.par) begin
            sn = dot3(cross3(c, b), n);
            tn = dot3(cross3(c, a), n);
            if (sn >= 0 && sn <= d && tn >= 0 && tn <= d) begin
                for (int k = 0; k < 3; k++) w[k] = a[k] * sn - b[k] * tn - d * c[k];
                mag = dot3(w, w);
                lim = cut_w * d * d;
                r.hit = (mag <= lim);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_verdict e;
        if (!i_rst_n) begin
            cutoff_sq = '0;
            par_thr   = '0;
            verdict_q.delete();
            errors    = 0;
        end else begin
            // results of earlier transactions come out before this edge's input is counted
            if (i_done) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result within=%0b parallel=%0b",
                                               i_within, i_parallel);
                end else begin
                    e = verdict_q.pop_front();
                    if (e.hit !== i_within || e.par !== i_parallel) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected within=%0b parallel=%0b, got %0b %0b",
                                     e.hit, e.par, i_within, i_parallel);
                    end
                end
            end
            if (i_start && !i_busy)
                verdict_q.push_back(closest_approach(i_seg, cutoff_sq, par_thr));
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CUTOFF_SQ) cutoff_sq = i_cfg_wdata[31:0];
                else if (i_cfg_idx == CFG_PAR_THR) par_thr = i_cfg_wdata[THR_W-1:0];
            end
        end
    end

endmodule

// ===== bench/tb_segment_pair_cutoff_test_core.sv =====
// Testbench top for the segment pair cutoff test core: stimulus and verdict
module tb_segment_pair_cutoff_test_core;
    import spct_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = CFG_CUTOFF_SQ;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    t_seg             seg = '0;
    logic             o_done, o_within_cutoff, o_parallel;
    int               mismatches, pending;
    int               cycles = 0;
    int               idle_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    segment_pair_cutoff_test_core dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_i_start_x(seg.pis.x), .i_i_start_y(seg.pis.y), .i_i_start_z(seg.pis.z),
        .i_i_end_x(seg.pie.x),   .i_i_end_y(seg.pie.y),   .i_i_end_z(seg.pie.z),
        .i_j_start_x(seg.pjs.x), .i_j_start_y(seg.pjs.y), .i_j_start_z(seg.pjs.z),
        .i_j_end_x(seg.pje.x),   .i_j_end_y(seg.pje.y),   .i_j_end_z(seg.pje.z),
        .o_done, .o_within_cutoff, .o_parallel
    );

    spct_scoreboard u_scoreboard (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cfg_we, .i_cfg_idx,
        .i_cfg_wdata, .i_seg(seg), .i_done(o_done), .i_within(o_within_cutoff),
        .i_parallel(o_parallel), .o_mismatches(mismatches), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("segment_pair_cutoff_test_core test failed");
            $finish;
        end
    end

    function automatic t_pt pt(int x, int y, int z);
        t_pt p;
        p.x = COORD_W'(x);
        p.y = COORD_W'(y);
        p.z = COORD_W'(z);
        return p;
    endfunction

    function automatic t_seg pair(t_pt is, t_pt ie, t_pt js, t_pt je);
        t_seg s;
        s.pis = is;
        s.pie = ie;
        s.pjs = js;
        s.pje = je;
        return s;
    endfunction

    function automatic int srand(int lim);
        return $urandom_range(2 * lim) - lim;
    endfunction

    function automatic t_pt rand_pt();
        t_pt p;
        p.x = COORD_W'($urandom);
        p.y = COORD_W'($urandom);
        p.z = COORD_W'($urandom);
        return p;
    endfunction

    // fully random segments, or segments crossing near a common point, sometimes pushed apart or made parallel
    function automatic t_seg random_pair();
        int px, py, pz, ux, uy, uz, vx, vy, vz, dx, dy, dz, kind;
        kind = $urandom_range(99);
        if (kind < 25) return pair(rand_pt(), rand_pt(), rand_pt(), rand_pt());
        px = srand(8000); py = srand(8000); pz = srand(8000);
        ux = srand(4000); uy = srand(4000); uz = srand(4000);
        vx = srand(4000); vy = srand(4000); vz = srand(4000);
        dx = srand(64);   dy = srand(64);   dz = srand(64);
        if (kind < 40) begin
            vx = ux + srand(2); vy = uy + srand(2); vz = uz + srand(2);
        end else if (kind < 50) begin
            // move J off the end of I
            dx = ux + srand(3000); dy = uy + srand(3000); dz = uz + srand(3000);
        end else if (kind < 55) begin
            dx = 0; dy = 0; dz = 0;
        end
        return pair(pt(px - ux, py - uy, pz - uz), pt(px + ux, py + uy, pz + uz),
                    pt(px + dx - vx, py + dy - vy, pz + dz - vz),
                    pt(px + dx + vx, py + dy + vy, pz + dz + vz));
    endfunction

    task automatic send(t_seg s);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        seg   <= s;
        start <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_run(int count);
        for (int k = 0; k < count; k++) begin
            send(random_pair());
            // hold off once mid-phase until the pipeline is empty
            if (k == count / 2) drain();
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items at the reset register values
        send(pair(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768),
                  pt(-32768, -32768, -32768), pt(-32768, -32768, -32768)));
        send(pair(pt(32767, 32767, 32767), pt(32767, 32767, 32767),
                  pt(32767, 32767, 32767), pt(32767, 32767, 32767)));
        send(pair(pt(-32768, 0, 0), pt(32767, 0, 0), pt(0, -32768, 0), pt(0, 32767, 0)));
        send(pair(pt(-32768, -32768, 32767), pt(32767, 32767, -32768),
                  pt(32767, -32768, -32768), pt(-32768, 32767, 32767)));
        send(pair(pt(-100, 0, 0), pt(100, 0, 0), pt(0, -100, 0), pt(0, 100, 0)));
        send(pair(pt(-100, 0, 0), pt(100, 0, 0), pt(0, -100, 5), pt(0, 100, 5)));
        send(pair(pt(0, 0, 0), pt(100, 0, 0), pt(0, 50, 0), pt(100, 50, 0)));
        send(pair(pt(-100, 0, 0), pt(100, 0, 0), pt(300, -100, 0), pt(300, 100, 0)));
        send(pair(pt(10, 10, 10), pt(10, 10, 10), pt(0, -100, 0), pt(0, 100, 0)));
        send(pair(pt(0, 0, 0), pt(256, 256, 0), pt(256, 0, 0), pt(0, 256, 0)));
        drain();

        cfg_write(CFG_CUTOFF_SQ, {31'h7fffffff, 32'hffffffff});
        cfg_write(CFG_PAR_THR, '0);
        send(pair(pt(-100, 0, 0), pt(100, 0, 0), pt(0, -100, 5), pt(0, 100, 5)));
        send(pair(pt(-32768, 0, 0), pt(32767, 0, 0), pt(0, -32768, 32767),
                  pt(0, 32767, -32768)));
        send(pair(pt(-100, 0, 0), pt(100, 0, 0), pt(101, -100, 0), pt(101, 100, 0)));
        idle_pct = 20;
        random_run(200);

        cfg_write(CFG_CUTOFF_SQ, 63'($urandom_range(5000, 2000)));
        cfg_write(CFG_PAR_THR, {23'b0, 40'($urandom) << 8});
        idle_pct = 86;
        random_run(200);

        cfg_write(CFG_CUTOFF_SQ, {31'($urandom), 32'($urandom)});
        cfg_write(CFG_PAR_THR, {13'b0, $urandom, 18'($urandom)});
        idle_pct = 0;
        random_run(180);

        cfg_write(CFG_CUTOFF_SQ, '0);
        cfg_write(CFG_PAR_THR, {1'b0, {62{1'b1}}});
        random_run(20);

        if (mismatches == 0 && pending == 0)
            $display("segment_pair_cutoff_test_core test passed");
        else
            $display("segment_pair_cutoff_test_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/spct_pkg.sv
design/spct_cross.sv
design/spct_scale.sv
design/spct_mag.sv
design/segment_pair_cutoff_test_core.sv
design/spct_checker.sv
bench/spct_checker.sv
bench/tb_segment_pair_cutoff_test_core.sv
